// ===== src/octc_pkg.sv =====
// Package for the oscillator trim calibrator: word widths, register indexes,
// sequencer state type and fixed constants. No dependencies.
`default_nettype none

package octc_pkg;

    localparam int TRIM_W   = 8;
    localparam int CNT_W    = 16;
    localparam int MEAS_W   = 17;
    localparam int FREQ_W   = 32;
    localparam int STEP_W   = 5;
    localparam int NUM_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Ticks per measurement: the first delta is dropped, the next two averaged.
    localparam int SAMPLES_PER_MEASURE = 3;

    // Shift-subtract divider: dividend register width and pass lengths.
    localparam int DVD_W      = 48;
    localparam int ITER_W     = 6;
    localparam int FREQ_STEPS = 48;
    localparam int INT_STEPS  = 24;

    localparam logic [FREQ_W-1:0] HALF_SCALE_Q16 = 32'h8000_0000;
    localparam logic [FREQ_W-1:0] COMP_SAT_D     = 32'h007F_0000;
    localparam logic [FREQ_W-1:0] ONE_HZ_Q16     = 32'h0001_0000;
    localparam logic signed [TRIM_W-1:0] TRIM_MAX = 8'sd127;
    localparam logic signed [TRIM_W-1:0] TRIM_MIN = -8'sd128;
    localparam logic signed [TRIM_W-1:0] COMP_MAX = 8'sd127;
    localparam logic signed [TRIM_W-1:0] COMP_MIN = -8'sd128;
    localparam logic [NUM_W-1:0] INTERVAL_MAX = 8'd255;

    // Input word kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // Result word events.
    localparam logic EVT_APPLY  = 1'b0;
    localparam logic EVT_FINISH = 1'b1;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_TARGET_COUNT = 3'd0;
    localparam t_cfg_idx REG_COUNTER_MOD  = 3'd1;
    localparam t_cfg_idx REG_REF_CLOCK_HZ = 3'd2;
    localparam t_cfg_idx REG_MAX_STEPS    = 3'd3;
    localparam t_cfg_idx REG_INTERVAL_NUM = 3'd4;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_DELTA  = 7'b0000010,
        ST_EVAL   = 7'b0000100,
        ST_DIVIDE = 7'b0001000,
        ST_POST   = 7'b0010000,
        ST_COMP   = 7'b0100000,
        ST_LOAD   = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// ===== src/octc_in_if.sv =====
// Input channel of the oscillator trim calibrator: valid/ready plus the
// input word fields. Depends on octc_pkg for field widths.
`default_nettype none

interface octc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   kind;
    logic signed [octc_pkg::TRIM_W-1:0]     initial_trim;
    logic        [octc_pkg::CNT_W-1:0]      ref_count;

    modport source (output valid, kind, initial_trim, ref_count, input ready);
    modport sink   (input valid, kind, initial_trim, ref_count, output ready);
endinterface

`default_nettype wire

// ===== src/octc_out_if.sv =====
// Result channel of the oscillator trim calibrator: valid/ready plus the
// result word fields. Depends on octc_pkg for field widths.
`default_nettype none

interface octc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   event_res;
    logic signed [octc_pkg::TRIM_W-1:0]     trim_value;
    logic        [octc_pkg::CNT_W-1:0]      measured_count;
    logic        [octc_pkg::FREQ_W-1:0]     freq_q16;
    logic                                   comp_valid;
    logic        [octc_pkg::NUM_W-1:0]      comp_interval;
    logic signed [octc_pkg::TRIM_W-1:0]     comp_value;

    modport source (output valid, event_res, trim_value, measured_count, freq_q16,
                    comp_valid, comp_interval, comp_value, input ready);
    modport sink   (input valid, event_res, trim_value, measured_count, freq_q16,
                    comp_valid, comp_interval, comp_value, output ready);
endinterface

`default_nettype wire

// ===== src/oscillator_trim_calibrator.sv =====
// Top level of the oscillator trim calibrator: measurement sequencer, trim
// search and a shared shift-subtract divider. Depends on octc_pkg and the
// octc_in_if / octc_out_if channel interfaces.
//
//   Channel     Direction  Handshake      Word contents
//   i_word_in   in         valid/ready    kind, initial_trim, ref_count
//   o_word_out  out        valid/ready    event_res, trim_value, measured_count,
//                                         freq_q16, comp_valid, comp_interval,
//                                         comp_value
//   i_cfg_*     in         write enable   register index, write data
//
// A start word or an ignored tick stays idle, the first two ticks of a measurement visit
// the delta state, and a closing tick that applies a new trim goes on to evaluation and
// load. A finishing tick runs the shared divider, one quotient bit a cycle, 48 for the
// frequency and 24 more for the interval when the error is below 1 Hz. A zero count skips
// it. Reset is synchronous and active low and needs no clearing pass. Input is ready only
// while idle; a result waits in the output register and the next one in the load state.
`default_nettype none

module oscillator_trim_calibrator (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    octc_in_if.sink                              i_word_in,
    octc_out_if.source                           o_word_out,
    input  wire                                  i_cfg_we,
    input  wire [octc_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [octc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import octc_pkg::*;

    // Configuration registers.
    logic [CNT_W-1:0]   r_target;
    logic [MEAS_W-1:0]  r_modulus;
    logic [CNT_W-1:0]   r_ref_hz;
    logic [STEP_W-1:0]  r_max_steps;
    logic [NUM_W-1:0]   r_int_num;

    // Search state.
    t_state             r_state;
    logic               r_armed;
    logic [1:0]         r_tick_idx;
    logic [CNT_W-1:0]   r_prev;
    logic [CNT_W-1:0]   r_cur;
    logic [MEAS_W-1:0]  r_delta_one;
    logic [MEAS_W-1:0]  r_delta;
    logic [STEP_W-1:0]  r_step;
    logic signed [TRIM_W-1:0] r_trim_now;
    logic signed [TRIM_W-1:0] r_trim_before;
    logic [MEAS_W-1:0]  r_meas_before;

    // Result being built.
    logic               r_evt;
    logic signed [TRIM_W-1:0] r_res_trim;
    logic [MEAS_W-1:0]  r_count;
    logic [FREQ_W-1:0]  r_freq;
    logic               r_cvalid;
    logic [NUM_W-1:0]   r_cint;
    logic signed [TRIM_W-1:0] r_cval;

    // Shared divider.
    logic [MEAS_W-1:0]  r_rem;
    logic [DVD_W-1:0]   r_dq;
    logic [MEAS_W-1:0]  r_divisor;
    logic [ITER_W-1:0]  r_iter;
    logic               r_second;

    // Output register.
    logic               r_out_valid;
    logic               r_o_evt;
    logic signed [TRIM_W-1:0] r_o_trim;
    logic [CNT_W-1:0]   r_o_count;
    logic [FREQ_W-1:0]  r_o_freq;
    logic               r_o_cvalid;
    logic [NUM_W-1:0]   r_o_cint;
    logic signed [TRIM_W-1:0] r_o_cval;

    logic               in_acc;
    logic               out_free;

    assign i_word_in.ready = (r_state == ST_IDLE);
    assign in_acc   = i_word_in.valid && i_word_in.ready;
    assign out_free = !r_out_valid || o_word_out.ready;

    // ---------------- Delta of two counter samples ----------------
    logic [MEAS_W:0]    wrap_sum;
    logic [MEAS_W-1:0]  delta_now;

    always_comb begin
        wrap_sum = {2'b00, r_cur} + {1'b0, r_modulus} - {2'b00, r_prev};
        if (r_cur < r_prev) begin
            delta_now = wrap_sum[MEAS_W-1:0];
        end else begin
            delta_now = {1'b0, r_cur - r_prev};
        end
    end

    // ---------------- Measurement evaluation ----------------
    logic [MEAS_W:0]    avg_sum;
    logic [MEAS_W-1:0]  avg;
    logic [MEAS_W-1:0]  tgt;
    logic               fast;
    logic               crossed;
    logic [MEAS_W-1:0]  dist_cur;
    logic [MEAS_W-1:0]  dist_prev;
    logic signed [TRIM_W-1:0] trim_stepped;
    logic [STEP_W-1:0]  step_next;

    always_comb begin
        avg_sum = {1'b0, r_delta_one} + {1'b0, r_delta};
        avg     = avg_sum[MEAS_W:1];
        tgt     = {1'b0, r_target};
        fast    = avg > tgt;
        crossed = (r_step != '0) &&
                  (fast ? (r_meas_before < tgt) : (r_meas_before > tgt));
        dist_cur  = (avg > tgt) ? avg - tgt : tgt - avg;
        dist_prev = (r_meas_before > tgt) ? r_meas_before - tgt : tgt - r_meas_before;
        if (fast) begin
            trim_stepped = (r_trim_now == TRIM_MIN) ? TRIM_MIN : r_trim_now - 8'sd1;
        end else begin
            trim_stepped = (r_trim_now == TRIM_MAX) ? TRIM_MAX : r_trim_now + 8'sd1;
        end
        step_next = r_step + 5'd1;
    end

    // ---------------- Divider step ----------------
    logic [MEAS_W:0]    trial_in;
    logic [MEAS_W:0]    trial_diff;
    logic               trial_ge;

    always_comb begin
        trial_in   = {r_rem, r_dq[DVD_W-1]};
        trial_diff = trial_in - {1'b0, r_divisor};
        trial_ge   = trial_in >= {1'b0, r_divisor};
    end

    // ---------------- Compensation decision ----------------
    logic               slow;
    logic [FREQ_W-1:0]  dev;
    logic [24:0]        dev_round;

    always_comb begin
        slow      = !r_freq[FREQ_W-1];
        dev       = r_freq[FREQ_W-1] ? r_freq - HALF_SCALE_Q16 : HALF_SCALE_Q16 - r_freq;
        dev_round = {1'b0, dev[23:0]} + 25'h0_8000;
    end

    // ---------------- Configuration writes ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= 16'd31250;
            r_modulus   <= 17'd62500;
            r_ref_hz    <= 16'd31250;
            r_max_steps <= 5'd16;
            r_int_num   <= 8'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET_COUNT: r_target    <= i_cfg_data[CNT_W-1:0];
                REG_COUNTER_MOD:  r_modulus   <= i_cfg_data[MEAS_W-1:0];
                REG_REF_CLOCK_HZ: r_ref_hz    <= i_cfg_data[CNT_W-1:0];
                REG_MAX_STEPS:    r_max_steps <= i_cfg_data[STEP_W-1:0];
                REG_INTERVAL_NUM: r_int_num   <= i_cfg_data[NUM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- Sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_armed       <= 1'b0;
            r_tick_idx    <= '0;
            r_prev        <= '0;
            r_delta_one   <= '0;
            r_step        <= '0;
            r_trim_now    <= '0;
            r_trim_before <= '0;
            r_meas_before <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_word_in.kind == KIND_START) begin
                            // A start restarts the search even while armed.
                            r_trim_now    <= i_word_in.initial_trim;
                            r_trim_before <= '0;
                            r_meas_before <= '0;
                            r_tick_idx    <= '0;
                            r_step        <= '0;
                            r_armed       <= 1'b1;
                        end else if (r_armed) begin
                            r_cur   <= i_word_in.ref_count;
                            r_state <= ST_DELTA;
                        end
                    end
                end
                ST_DELTA: begin
                    r_prev <= r_cur;
                    if (r_tick_idx < 2'(SAMPLES_PER_MEASURE - 2)) begin
                        r_tick_idx <= r_tick_idx + 2'd1;
                        r_state    <= ST_IDLE;
                    end else if (r_tick_idx == 2'(SAMPLES_PER_MEASURE - 2)) begin
                        r_delta_one <= delta_now;
                        r_tick_idx  <= r_tick_idx + 2'd1;
                        r_state     <= ST_IDLE;
                    end else begin
                        r_delta    <= delta_now;
                        r_tick_idx <= '0;
                        r_state    <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    r_cvalid <= 1'b0;
                    r_cint   <= '0;
                    r_cval   <= '0;
                    r_rem    <= '0;
                    r_dq     <= {1'b0, r_ref_hz, 31'd0};
                    r_iter   <= ITER_W'(FREQ_STEPS - 1);
                    r_second <= 1'b0;
                    // A zero count saturates the frequency and skips the divider.
                    if (crossed) begin
                        // Strictly closer wins; a tie keeps the previous point.
                        r_evt   <= EVT_FINISH;
                        r_armed <= 1'b0;
                        if (dist_cur < dist_prev) begin
                            r_res_trim <= r_trim_now;
                            r_count    <= avg;
                            r_divisor  <= avg;
                            r_state    <= (avg == '0) ? ST_COMP : ST_DIVIDE;
                            r_freq     <= (avg == '0) ? '1 : '0;
                        end else begin
                            r_res_trim <= r_trim_before;
                            r_count    <= r_meas_before;
                            r_divisor  <= r_meas_before;
                            r_state    <= (r_meas_before == '0) ? ST_COMP : ST_DIVIDE;
                            r_freq     <= (r_meas_before == '0) ? '1 : '0;
                        end
                    end else begin
                        r_trim_before <= r_trim_now;
                        r_trim_now    <= trim_stepped;
                        r_meas_before <= avg;
                        r_step        <= step_next;
                        if (step_next >= r_max_steps) begin
                            // Search exhausted: report the last measurement.
                            r_evt      <= EVT_FINISH;
                            r_armed    <= 1'b0;
                            r_res_trim <= r_trim_now;
                            r_count    <= avg;
                            r_divisor  <= avg;
                            r_state    <= (avg == '0) ? ST_COMP : ST_DIVIDE;
                            r_freq     <= (avg == '0) ? '1 : '0;
                        end else begin
                            r_evt      <= EVT_APPLY;
                            r_res_trim <= trim_stepped;
                            r_count    <= '0;
                            r_freq     <= '0;
                            r_state    <= ST_LOAD;
                        end
                    end
                end
                ST_DIVIDE: begin
                    r_rem  <= trial_ge ? trial_diff[MEAS_W-1:0] : trial_in[MEAS_W-1:0];
                    r_dq   <= {r_dq[DVD_W-2:0], trial_ge};
                    r_iter <= r_iter - 6'd1;
                    if (r_iter == '0) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    if (r_second) begin
                        r_cint  <= (r_dq[INT_STEPS-1:NUM_W] != '0) ? INTERVAL_MAX
                                                                   : r_dq[NUM_W-1:0];
                        r_state <= ST_LOAD;
                    end else begin
                        r_freq  <= (r_dq[DVD_W-1:FREQ_W] != '0) ? '1 : r_dq[FREQ_W-1:0];
                        r_state <= ST_COMP;
                    end
                end
                ST_COMP: begin
                    r_cint <= '0;
                    if (dev == '0) begin
                        r_cvalid <= 1'b0;
                        r_cval   <= '0;
                        r_state  <= ST_LOAD;
                    end else if (dev >= COMP_SAT_D) begin
                        r_cvalid <= 1'b1;
                        r_cval   <= slow ? COMP_MAX : COMP_MIN;
                        r_state  <= ST_LOAD;
                    end else if (dev >= ONE_HZ_Q16) begin
                        r_cvalid <= 1'b1;
                        r_cval   <= slow ? $signed(dev_round[23:16])
                                         : -$signed(dev_round[23:16]);
                        r_state  <= ST_LOAD;
                    end else begin
                        // Below 1 Hz: one cycle every interval_numerator/dev seconds.
                        r_cvalid  <= 1'b1;
                        r_cval    <= slow ? 8'sd1 : -8'sd1;
                        r_rem     <= '0;
                        r_dq      <= {r_int_num, 16'd0, 24'd0};
                        r_divisor <= {1'b0, dev[15:0]};
                        r_iter    <= ITER_W'(INT_STEPS - 1);
                        r_second  <= 1'b1;
                        r_state   <= ST_DIVIDE;
                    end
                end
                ST_LOAD: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_LOAD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_word_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOAD && out_free) begin
            r_o_evt    <= r_evt;
            r_o_trim   <= r_res_trim;
            r_o_count  <= r_count[MEAS_W-1] ? '1 : r_count[CNT_W-1:0];
            r_o_freq   <= r_freq;
            r_o_cvalid <= r_cvalid;
            r_o_cint   <= r_cint;
            r_o_cval   <= r_cval;
        end
    end

    assign o_word_out.valid          = r_out_valid;
    assign o_word_out.event_res      = r_o_evt;
    assign o_word_out.trim_value     = r_o_trim;
    assign o_word_out.measured_count = r_o_count;
    assign o_word_out.freq_q16       = r_o_freq;
    assign o_word_out.comp_valid     = r_o_cvalid;
    assign o_word_out.comp_interval  = r_o_cint;
    assign o_word_out.comp_value     = r_o_cval;

endmodule

`default_nettype wire

// ===== src/octc_checker.sv =====
// Port-level checks for the oscillator trim calibrator and the bind that
// attaches them. Depends on octc_pkg and oscillator_trim_calibrator.
`default_nettype none

module octc_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_in_valid,
    input wire                                  i_in_ready,
    input wire                                  i_in_kind,
    input wire                                  i_out_valid,
    input wire                                  i_out_ready,
    input wire                                  i_out_event,
    input wire [octc_pkg::FREQ_W-1:0]           i_out_freq,
    input wire                                  i_out_cvalid,
    input wire [octc_pkg::NUM_W-1:0]            i_out_cint,
    input wire [octc_pkg::TRIM_W-1:0]           i_out_cval
);
    import octc_pkg::*;

    // A stalled result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    // A start word never makes a new result appear.
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind == KIND_START && !i_out_valid
        |=> !i_out_valid)
        else $error("start word produced a result");

    // An apply-trim word carries no frequency or compensation.
    a_apply_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_event == EVT_APPLY
        |-> i_out_freq == '0 && !i_out_cvalid && i_out_cint == '0 && i_out_cval == '0)
        else $error("apply-trim word with nonzero finish fields");

    // A nonzero interval only comes with a one-cycle correction.
    a_interval_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_cint != '0
        |-> i_out_cvalid && (i_out_cval == 8'h01 || i_out_cval == 8'hFF))
        else $error("compensation interval without unit value");

    // After reset the block is idle and takes words.
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("not ready after reset");

endmodule

bind oscillator_trim_calibrator octc_checker u_octc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_word_in.valid),
    .i_in_ready   (i_word_in.ready),
    .i_in_kind    (i_word_in.kind),
    .i_out_valid  (o_word_out.valid),
    .i_out_ready  (o_word_out.ready),
    .i_out_event  (o_word_out.event_res),
    .i_out_freq   (o_word_out.freq_q16),
    .i_out_cvalid (o_word_out.comp_valid),
    .i_out_cint   (o_word_out.comp_interval),
    .i_out_cval   (o_word_out.comp_value)
);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for oscillator_trim_calibrator: a local predictor of the
// trim search, driven by directed and shaped random start/tick words on the input
// channel. Depends on octc_pkg, octc_in_if and octc_out_if from the RTL.
`timescale 1ns / 100ps

module tb;
    import octc_pkg::*;

    // The slowest correct run is far below this, even with every word waiting out
    // the full divider, the longest gaps and the back-pressure hold.
    localparam int CYCLE_LIMIT  = 400000;
    // Cycles allowed after the last expected word before a register write or the
    // end of the run.
    localparam int SETTLE_CYCLES = 120;

    typedef struct packed {
        logic                event_res;
        logic [TRIM_W-1:0]   trim_value;
        logic [CNT_W-1:0]    measured_count;
        logic [FREQ_W-1:0]   freq_q16;
        logic                comp_valid;
        logic [NUM_W-1:0]    comp_interval;
        logic [TRIM_W-1:0]   comp_value;
    } t_trim_report;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    octc_in_if  word_in ();
    octc_out_if word_out ();

    oscillator_trim_calibrator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word_in  (word_in),
        .o_word_out (word_out),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Predicted register contents.
    logic [15:0] cfg_target;
    logic [16:0] cfg_modulus;
    logic [15:0] cfg_ref_hz;
    logic [4:0]  cfg_max_steps;
    logic [7:0]  cfg_interval_num;

    // Predicted search state.
    logic               search_armed;
    logic [1:0]         tick_phase;
    logic [15:0]        last_sample;
    logic [16:0]        first_delta;
    logic [4:0]         steps_done;
    logic signed [7:0]  trim_cur;
    logic signed [7:0]  trim_prev;
    logic [16:0]        count_prev;

    // Result words the block still owes us, oldest first.
    t_trim_report pending_reports[$];

    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  phase_words = 0;       // counted words left in the current random phase
    int  ref_counter_now = 0;   // last reference counter value we sent
    int  hold_off_cycles = 0;   // one long receiver stall, taken by the receiver
    bit  tx_gap_on = 1'b1;
    bit  rx_stall_on = 1'b1;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [16:0] target_gap(input logic [16:0] v);
        return (v > {1'b0, cfg_target}) ? v - {1'b0, cfg_target} : {1'b0, cfg_target} - v;
    endfunction

    // Final word of a search: frequency in Q16.16 from an exact long division, then
    // the RTC compensation derived from its distance to 32768 Hz.
    function automatic t_trim_report closing_report(input logic [7:0] trim,
                                                    input logic [16:0] count);
        t_trim_report r;
        logic [47:0]  quot;
        logic [31:0]  freq;
        logic [31:0]  err;
        logic [23:0]  ratio;
        logic [7:0]   mag;
        logic         slow;
        r = '0;
        r.event_res = EVT_FINISH;
        r.trim_value = trim;
        r.measured_count = (count > 17'h0FFFF) ? 16'hFFFF : count[15:0];
        // A zero count has no meaningful quotient and saturates like an overflow.
        if (count == '0) begin
            freq = '1;
        end else begin
            quot = {1'b0, cfg_ref_hz, 31'b0} / {31'b0, count};
            freq = (quot > 48'h0000_FFFF_FFFF) ? '1 : quot[31:0];
        end
        r.freq_q16 = freq;
        err = (freq >= HALF_SCALE_Q16) ? freq - HALF_SCALE_Q16 : HALF_SCALE_Q16 - freq;
        slow = freq < HALF_SCALE_Q16;
        if (err != '0) begin
            r.comp_valid = 1'b1;
            if (err >= COMP_SAT_D) begin
                r.comp_value = slow ? COMP_MAX : COMP_MIN;
            end else if (err >= ONE_HZ_Q16) begin
                // Whole hertz, rounded half away from zero.
                mag = 8'((err + 32'h0000_8000) >> 16);
                r.comp_value = slow ? mag : 8'd0 - mag;
            end else begin
                // Under one hertz: a single cycle every so many seconds.
                ratio = {cfg_interval_num, 16'b0} / err[23:0];
                r.comp_interval = (ratio > {16'b0, INTERVAL_MAX}) ? INTERVAL_MAX : ratio[7:0];
                r.comp_value = slow ? 8'd1 : 8'hFF;
            end
        end
        return r;
    endfunction

    // One accepted input word applied to the predicted search state.
    function automatic void trim_search_step(input logic kind, input logic [7:0] trim_in,
                                             input logic [15:0] sample);
        logic [17:0]  sum;
        logic [16:0]  delta;
        logic [16:0]  avg;
        logic         fast;
        logic         crossed;
        t_trim_report r;
        if (kind == KIND_START) begin
            trim_cur = trim_in;
            trim_prev = '0;
            count_prev = '0;
            tick_phase = '0;
            steps_done = '0;
            search_armed = 1'b1;
            return;
        end
        // A tick while no search runs leaves even the previous sample alone.
        if (!search_armed) return;
        // The sample wrapped when it is below the previous one; the delta is
        // kept to 17 bits, so a zero modulus simply wraps.
        if (sample < last_sample) begin
            sum = {2'b0, sample} + {1'b0, cfg_modulus} - {2'b0, last_sample};
            delta = sum[16:0];
        end else begin
            delta = {1'b0, sample - last_sample};
        end
        last_sample = sample;
        if (tick_phase == 2'd0) begin
            tick_phase = 2'd1;
            return;
        end
        if (tick_phase == 2'd1) begin
            first_delta = delta;
            tick_phase = 2'd2;
            return;
        end
        tick_phase = 2'd0;
        sum = {1'b0, first_delta} + {1'b0, delta};
        avg = sum[17:1];
        fast = avg > {1'b0, cfg_target};
        crossed = (steps_done != '0) &&
                  (fast ? count_prev < {1'b0, cfg_target} : count_prev > {1'b0, cfg_target});
        if (crossed) begin
            // Ties keep the earlier measurement.
            if (target_gap(avg) < target_gap(count_prev))
                r = closing_report(trim_cur, avg);
            else
                r = closing_report(trim_prev, count_prev);
            search_armed = 1'b0;
            pending_reports.push_back(r);
            return;
        end
        trim_prev = trim_cur;
        if (fast)
            trim_cur = (trim_cur == TRIM_MIN) ? TRIM_MIN : trim_cur - 8'sd1;
        else
            trim_cur = (trim_cur == TRIM_MAX) ? TRIM_MAX : trim_cur + 8'sd1;
        count_prev = avg;
        steps_done = steps_done + 5'd1;
        // Out of steps: report the last measurement. A zero limit acts like one.
        if (steps_done >= cfg_max_steps) begin
            r = closing_report(trim_prev, avg);
            search_armed = 1'b0;
        end else begin
            r = '0;
            r.event_res = EVT_APPLY;
            r.trim_value = trim_cur;
        end
        pending_reports.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offers one word and returns at the falling edge after it was taken, with
    // valid still high so that a back-to-back word keeps it up.
    task automatic send_word(input logic kind, input logic [7:0] trim, input logic [15:0] sample);
        int gap;
        gap = tx_gap_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            word_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        word_in.valid <= 1'b1;
        word_in.kind <= kind;
        word_in.initial_trim <= trim;
        word_in.ref_count <= sample;
        do @(posedge i_clk); while (word_in.ready !== 1'b1);
        // Ticks while no search runs are ignored and do not count as stimulus.
        if (kind == KIND_START || search_armed) phase_words--;
        trim_search_step(kind, trim, sample);
        ref_counter_now = sample;
        @(negedge i_clk);
    endtask

    function automatic int counter_span();
        return (cfg_modulus == 17'd0 || cfg_modulus > 17'h10000) ? 65536 : int'(cfg_modulus);
    endfunction

    // Advances the reference counter by the given amount, wrapping at the modulus.
    task automatic send_tick_delta(input int delta);
        send_word(KIND_TICK, 8'($urandom), 16'((ref_counter_now + delta) % counter_span()));
    endtask

    // Lowers valid, waits for every expected word and lets the block settle.
    task automatic wait_idle();
        word_in.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] target, input logic [16:0] modulus,
                              input logic [15:0] ref_hz, input logic [4:0] max_steps,
                              input logic [7:0] interval_num);
        t_cfg_idx    regs [5];
        logic [16:0] values [5];
        int          i;
        regs = '{REG_TARGET_COUNT, REG_COUNTER_MOD, REG_REF_CLOCK_HZ, REG_MAX_STEPS,
                 REG_INTERVAL_NUM};
        values = '{{1'b0, target}, modulus, {1'b0, ref_hz}, {12'b0, max_steps},
                   {9'b0, interval_num}};
        for (i = 0; i < 5; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= regs[i];
            cfg_data <= values[i];
            @(negedge i_clk);
        end
        cfg_we <= 1'b0;
        cfg_target = target;
        cfg_modulus = modulus;
        cfg_ref_hz = ref_hz;
        cfg_max_steps = max_steps;
        cfg_interval_num = interval_num;
    endtask

    // Random searches against a simple oscillator: the averaged count rises with
    // the applied trim by a random slope and crosses the target near a random
    // trim, so most searches converge. Some start far away and run out of steps;
    // a few samples are pure noise and a few starts cut a search short.
    task automatic run_searches(input int words);
        logic signed [7:0] start_trim;
        int                base_trim;
        int                zero_trim;
        int                slope;
        int                delta;
        int                span;
        phase_words = words;
        while (phase_words > 0) begin
            start_trim = 8'($urandom);
            if ($urandom_range(0, 7) == 0)
                start_trim = $urandom_range(0, 1) ? TRIM_MAX : TRIM_MIN;
            base_trim = start_trim;
            zero_trim = base_trim + int'($urandom_range(0, 12)) - 6;
            if ($urandom_range(0, 9) == 0)
                zero_trim = base_trim + ($urandom_range(0, 1) ? 70 : -70);
            slope = $urandom_range(1, 40);
            send_word(KIND_START, start_trim, 16'($urandom));
            while (search_armed && phase_words > 0) begin
                span = counter_span();
                if ($urandom_range(0, 39) == 0) begin
                    send_word(KIND_START, 8'($urandom), 16'($urandom));
                end else begin
                    // The first delta of a measurement is dropped by the block.
                    if (tick_phase == 2'd0 || $urandom_range(0, 19) == 0)
                        delta = $urandom_range(0, span - 1);
                    else
                        delta = int'(cfg_target) + slope * (int'(trim_cur) - zero_trim)
                                + int'($urandom_range(0, 2)) - 1;
                    if (delta < 0) delta = 0;
                    if (delta > span - 1) delta = span - 1;
                    send_tick_delta(delta);
                end
            end
            repeat ($urandom_range(0, 2)) send_word(KIND_TICK, 8'($urandom), 16'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Trim saturation at both ends, counter wrap, a tick while idle, the closer of
    // two measurements in both directions, an exact hit with no compensation, a
    // restart while armed, a zero step limit with sub-hertz error, and a zero
    // count that saturates the frequency.
    task automatic test_directed_edges();
        send_word(KIND_TICK, 8'h00, 16'hFFFF);
        send_word(KIND_START, TRIM_MAX, 16'h0000);
        send_tick_delta(100);
        send_tick_delta(0);
        send_tick_delta(0);
        send_tick_delta(7);
        send_tick_delta(62499);
        send_tick_delta(62499);
        send_word(KIND_START, TRIM_MIN, 16'hFFFF);
        send_tick_delta(0);
        send_tick_delta(62499);
        send_tick_delta(62499);
        send_tick_delta(0);
        send_tick_delta(31250);
        send_tick_delta(31250);
        wait_idle();
        set_config(16'd65535, 17'h10000, 16'd65535, 5'd0, 8'd255);
        send_word(KIND_START, 8'sd5, 16'h5555);
        send_tick_delta(7);
        send_word(KIND_START, 8'sd0, 16'hAAAA);
        send_tick_delta(1);
        send_tick_delta(65534);
        send_tick_delta(65534);
        wait_idle();
        set_config(16'd1, 17'd1, 16'd1, 5'd1, 8'd1);
        send_word(KIND_START, 8'hFF, 16'h0000);
        send_tick_delta(0);
        send_tick_delta(0);
        send_tick_delta(0);
        wait_idle();
    endtask

    task automatic test_default_search();
        set_config(16'd31250, 17'd62500, 16'd31250, 5'd16, 8'd30);
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
        run_searches(80);
        wait_idle();
    endtask

    // Counts within a few units of a large reference frequency give the
    // sub-hertz compensation; both sides run without idling here.
    task automatic test_fine_compensation();
        set_config(16'd65000, 17'h10000, 16'd65000, 5'd31, 8'($urandom_range(1, 255)));
        tx_gap_on = 1'b0;
        rx_stall_on = 1'b0;
        run_searches(60);
        wait_idle();
        tx_gap_on = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // The receiver stops for a long stretch while searches keep producing trim
    // words, so the result register and the load stage fill and input stalls.
    task automatic test_output_backpressure();
        logic [15:0] target;
        target = 16'($urandom_range(20000, 40000));
        set_config(target, 17'd62500, target, 5'($urandom_range(8, 31)),
                   8'($urandom_range(1, 255)));
        hold_off_cycles = 400;
        run_searches(80);
        wait_idle();
    endtask

    // With a zero modulus a wrapped sample gives a delta above 16 bits, which
    // exercises the measured-count saturation.
    task automatic test_zero_modulus();
        set_config(16'd30000, 17'd0, 16'd30000, 5'd12, 8'd100);
        run_searches(50);
        wait_idle();
    endtask

    task automatic test_saturated_frequency();
        set_config(16'($urandom_range(1, 8)), 17'd1000, 16'd65535, 5'd31, 8'd1);
        run_searches(50);
        wait_idle();
    endtask

    task automatic test_random_config();
        logic [15:0] target;
        repeat (3) begin
            target = 16'($urandom_range(1, 65535));
            set_config(target, 17'($urandom_range(target, 65536)),
                       $urandom_range(0, 1) ? target : 16'($urandom_range(1, 65535)),
                       5'($urandom_range(1, 31)), 8'($urandom_range(1, 255)));
            run_searches(45);
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------

    // Before each word the receiver holds ready low for a drawn number of cycles,
    // or once for the long hold requested by the back-pressure test.
    initial begin
        int wait_cycles;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                wait_cycles = hold_off_cycles;
                hold_off_cycles = 0;
            end else begin
                wait_cycles = rx_stall_on ? $urandom_range(0, 3) : 0;
            end
            if (wait_cycles > 0) begin
                word_out.ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            word_out.ready <= 1'b1;
            do @(posedge i_clk); while (word_out.valid !== 1'b1);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_trim_report want;
        if (i_rst_n === 1'b1 && word_out.valid === 1'b1 && word_out.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                $display("%0t: result word with none expected, trim %h, event %b", $time,
                         word_out.trim_value, word_out.event_res);
            end else begin
                want = pending_reports.pop_front();
                check_field("event_res", want.event_res, word_out.event_res);
                check_field("trim_value", want.trim_value, $unsigned(word_out.trim_value));
                check_field("measured_count", want.measured_count, word_out.measured_count);
                check_field("freq_q16", want.freq_q16, word_out.freq_q16);
                check_field("comp_valid", want.comp_valid, word_out.comp_valid);
                check_field("comp_interval", want.comp_interval, word_out.comp_interval);
                check_field("comp_value", want.comp_value, $unsigned(word_out.comp_value));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time, pending_reports.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        word_in.valid = 1'b0;
        word_in.kind = KIND_START;
        word_in.initial_trim = '0;
        word_in.ref_count = '0;
        word_out.ready = 1'b0;
        cfg_target = 16'd31250;
        cfg_modulus = 17'd62500;
        cfg_ref_hz = 16'd31250;
        cfg_max_steps = 5'd16;
        cfg_interval_num = 8'd30;
        search_armed = 1'b0;
        tick_phase = '0;
        last_sample = '0;
        first_delta = '0;
        steps_done = '0;
        trim_cur = '0;
        trim_prev = '0;
        count_prev = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_edges();
        test_default_search();
        test_fine_compensation();
        test_output_backpressure();
        test_zero_modulus();
        test_saturated_frequency();
        test_random_config();

        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
